FILE: sv/sll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_pkg
// Shared constants, codes and types of the static linked list engine.
// ----------------------------------------------------------------------------
package sll_pkg;

	localparam int NODES  = 1024;
	localparam int NODE_W = $clog2(NODES);
	localparam int POS_W  = 10;
	localparam int DATA_W = 8;

	localparam logic [NODE_W-1:0] HEAD_NODE = NODE_W'(NODES - 1);
	localparam logic [NODE_W-1:0] LAST_FREE = NODE_W'(NODES - 2);
	localparam logic [POS_W-1:0]  MAX_LEN   = POS_W'(NODES - 2);

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_INSERT = 2'd0;
	localparam mode_t MODE_DELETE = 2'd1;
	localparam mode_t MODE_READ   = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t STAT_OK     = 2'd0;
	localparam status_t STAT_BADPOS = 2'd1;
	localparam status_t STAT_FULL   = 2'd2;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_INS_FREE,
		ST_INS_NEXT,
		ST_WALK,
		ST_INS_LINK,
		ST_INS_K,
		ST_DEL_J,
		ST_DEL_NJ,
		ST_DEL_F,
		ST_DEL_FW,
		ST_DEL_H,
		ST_RD_J,
		ST_RD_D,
		ST_RESP
	} seq_state_t;

	typedef struct packed {
		logic              link_we;
		logic [NODE_W-1:0] link_addr;
		logic [NODE_W-1:0] link_wdata;
		logic              elem_we;
		logic [NODE_W-1:0] elem_addr;
		logic [DATA_W-1:0] elem_wdata;
	} mem_req_t;

	typedef struct packed {
		logic [NODE_W-1:0] link_rdata;
		logic [DATA_W-1:0] elem_rdata;
	} mem_rsp_t;

endpackage

FILE: sv/sll_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_store
// Link and element memories, one port each, read data registered.
// ----------------------------------------------------------------------------
module sll_store
	import sll_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output mem_rsp_t rsp
);

	logic [NODE_W-1:0] link_mem [NODES];
	logic [DATA_W-1:0] elem_mem [NODES];

	always_ff @(posedge clk) begin
		if (req.link_we) begin
			link_mem[req.link_addr] <= req.link_wdata;
		end
		if (req.elem_we) begin
			elem_mem[req.elem_addr] <= req.elem_wdata;
		end
		rsp.link_rdata <= link_mem[req.link_addr];
		rsp.elem_rdata <= elem_mem[req.elem_addr];
	end

endmodule

FILE: sv/sll_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_seq
// Request sequencer: link init sweep, chain walk and read-modify-write steps.
// ----------------------------------------------------------------------------
module sll_seq
	import sll_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mode_t             mode,
	input  logic [POS_W-1:0]  position,
	input  logic [DATA_W-1:0] data_in,
	output logic              busy,
	output logic              done,
	output status_t           status,
	output logic [DATA_W-1:0] data_out,
	output logic [POS_W-1:0]  list_length,
	output mem_req_t          req,
	input  mem_rsp_t          rsp
);

	seq_state_t        state_q, state_d;
	logic [NODE_W-1:0] init_q;
	logic [POS_W-1:0]  count_q;
	logic              pend_q;
	mode_t             mode_q;
	logic [POS_W-1:0]  steps_q;
	logic [DATA_W-1:0] byte_q;
	logic [NODE_W-1:0] k_q;
	logic [NODE_W-1:0] j_q;
	status_t           status_q;
	logic [DATA_W-1:0] dout_q;
	logic [NODE_W-1:0] cur;
	logic              ins_ok;
	logic              pos_ok;

	assign cur    = pend_q ? rsp.link_rdata : k_q;
	assign pos_ok = (position != '0) && (position <= count_q);
	assign ins_ok = (position != '0) &&
		({1'b0, position} <= ({1'b0, count_q} + (POS_W+1)'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			init_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= (state_q == ST_WALK) && (steps_q != '0);
			if (state_q == ST_INIT) begin
				init_q <= init_q + 1'b1;
			end
			if (state_q == ST_INS_K) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == ST_DEL_H) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mode_q   <= mode;
				steps_q  <= position - 1'b1;
				byte_q   <= data_in;
				status_q <= STAT_BADPOS;
				dout_q   <= '0;
				k_q      <= HEAD_NODE;
			end
			ST_INS_FREE: begin
				j_q <= rsp.link_rdata;
				if (rsp.link_rdata == '0) begin
					status_q <= STAT_FULL;
				end
			end
			ST_WALK: begin
				if (steps_q == '0) begin
					k_q <= cur;
				end else begin
					steps_q <= steps_q - 1'b1;
				end
			end
			ST_DEL_J: begin
				j_q <= rsp.link_rdata;
			end
			ST_RD_D: begin
				dout_q   <= rsp.elem_rdata;
				status_q <= STAT_OK;
			end
			ST_INS_K, ST_DEL_H: begin
				status_q <= STAT_OK;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		req     = '0;
		case (state_q)
			ST_INIT: begin
				req.link_we    = 1'b1;
				req.link_addr  = init_q;
				req.link_wdata = (init_q < LAST_FREE) ? init_q + 1'b1 : '0;
				if (init_q == HEAD_NODE) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.link_addr = '0;
				if (start) begin
					case (mode)
						MODE_INSERT: state_d = ins_ok ? ST_INS_FREE : ST_RESP;
						MODE_DELETE, MODE_READ: state_d = pos_ok ? ST_WALK : ST_RESP;
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_INS_FREE: begin
				req.link_addr = rsp.link_rdata;
				state_d = (rsp.link_rdata == '0) ? ST_RESP : ST_INS_NEXT;
			end
			ST_INS_NEXT: begin
				req.link_we    = 1'b1;
				req.link_addr  = '0;
				req.link_wdata = rsp.link_rdata;
				req.elem_we    = 1'b1;
				req.elem_addr  = j_q;
				req.elem_wdata = byte_q;
				state_d        = ST_WALK;
			end
			ST_WALK: begin
				req.link_addr = cur;
				if (steps_q == '0) begin
					case (mode_q)
						MODE_INSERT: state_d = ST_INS_LINK;
						MODE_DELETE: state_d = ST_DEL_J;
						default:     state_d = ST_RD_J;
					endcase
				end
			end
			ST_INS_LINK: begin
				req.link_we    = 1'b1;
				req.link_addr  = j_q;
				req.link_wdata = rsp.link_rdata;
				state_d        = ST_INS_K;
			end
			ST_INS_K: begin
				req.link_we    = 1'b1;
				req.link_addr  = k_q;
				req.link_wdata = j_q;
				state_d        = ST_RESP;
			end
			ST_DEL_J: begin
				req.link_addr = rsp.link_rdata;
				state_d       = ST_DEL_NJ;
			end
			ST_DEL_NJ: begin
				req.link_we    = 1'b1;
				req.link_addr  = k_q;
				req.link_wdata = rsp.link_rdata;
				state_d        = ST_DEL_F;
			end
			ST_DEL_F: begin
				req.link_addr = '0;
				state_d       = ST_DEL_FW;
			end
			ST_DEL_FW: begin
				req.link_we    = 1'b1;
				req.link_addr  = j_q;
				req.link_wdata = rsp.link_rdata;
				state_d        = ST_DEL_H;
			end
			ST_DEL_H: begin
				req.link_we    = 1'b1;
				req.link_addr  = '0;
				req.link_wdata = j_q;
				state_d        = ST_RESP;
			end
			ST_RD_J: begin
				req.elem_addr = rsp.link_rdata;
				state_d       = ST_RD_D;
			end
			ST_RD_D: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_RESP);
	assign status      = status_q;
	assign data_out    = dout_q;
	assign list_length = count_q;

endmodule

FILE: sv/static_linked_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// static_linked_list_engine_unit
// Array-backed linked list of bytes with a free chain, one request at a time.
// ----------------------------------------------------------------------------
// A request (mode, position, data_in) transfers at a clock edge with start
// high and busy low. Mode insert puts data_in before a 1-based position,
// delete removes the element at a position, read returns it on data_out.
// Exactly one result follows per request: done is high for one cycle with
// status, data_out and list_length; the receiver cannot stall it.
// A rejected request, and an insert that finds the free chain empty, skip the
// walk down the link chain. The walk reads the single-port link memory once
// per node, so the time a request takes grows with its position. busy stays
// high from the request until done. After reset the link memory is
// initialized by a sweep, one entry a cycle, during which busy is high and
// no request is taken.
// ----------------------------------------------------------------------------
module static_linked_list_engine_unit
	import sll_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        mode,
	input  logic [POS_W-1:0]  position,
	input  logic [DATA_W-1:0] data_in,
	output logic              done,
	output logic [1:0]        status,
	output logic [DATA_W-1:0] data_out,
	output logic [POS_W-1:0]  list_length
);

	mem_req_t req;
	mem_rsp_t rsp;

	sll_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.mode        (mode),
		.position    (position),
		.data_in     (data_in),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.data_out    (data_out),
		.list_length (list_length),
		.req         (req),
		.rsp         (rsp)
	);

	sll_store u_store (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

endmodule

FILE: sv/sll_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_checker
// Port-level checks of the linked list engine, bound to the top level.
// ----------------------------------------------------------------------------
module sll_checker
	import sll_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [1:0]        status,
	input logic [DATA_W-1:0] data_out,
	input logic [POS_W-1:0]  list_length
);

	// a transfer is followed by busy, which the block keeps until its result
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request not followed by busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result while idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STAT_OK |-> data_out == '0 && $stable(list_length))
		else $error("failed request changed data or length");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_FULL |-> list_length == MAX_LEN)
		else $error("full status below capacity");

endmodule

bind static_linked_list_engine_unit sll_checker u_sll_checker (.*);
